// ===== design/im2col_2d_region_generator_assert.svh =====
// assertion macros for the im2col region generator
`ifndef IM2COL_2D_REGION_GENERATOR_ASSERT_SVH
`define IM2COL_2D_REGION_GENERATOR_ASSERT_SVH
`ifndef SYNTH
`define IM2C_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("im2col region generator check failed");
`define IM2C_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("im2col region generator check failed");
`else
`define IM2C_ASSERT_IMP(lbl, ante, cons)
`define IM2C_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/im2c_pkg.sv =====
// shared types and constants of the im2col region generator
package im2c_pkg;

    localparam int DIV_BITS = 14;
    localparam int DEN_BITS = 7;

    // descriptor kinds
    typedef enum logic [2:0] {
        K_MAIN  = 3'd0,
        K_UP    = 3'd1,
        K_BELOW = 3'd2,
        K_LEFT  = 3'd3,
        K_RIGHT = 3'd4
    } t_kind;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_IN_H   = 3'd0,
        CFG_IN_W   = 3'd1,
        CFG_OUT_H  = 3'd2,
        CFG_OUT_W  = 3'd3,
        CFG_STR_Y  = 3'd4,
        CFG_STR_X  = 3'd5,
        CFG_CHAN   = 3'd6,
        CFG_BATCH  = 3'd7
    } t_cfg_idx;

    // pending descriptor bits, in emit order
    localparam int MB_UP    = 0;
    localparam int MB_BELOW = 1;
    localparam int MB_LEFT  = 2;
    localparam int MB_RIGHT = 3;
    localparam int MB_MAIN  = 4;

    // tap fields that ride alongside the dividers
    typedef struct packed {
        logic [7:0]  tap;
        logic [13:0] rs;
        logic [13:0] cs;
        logic [23:0] srct;
        logic [8:0]  taps;
        logic        pad;
        logic        n2y;
        logic        n2x;
    } t_side;

endpackage

// ===== design/im2c_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module im2c_div import im2c_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [DIV_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic [DIV_BITS-1:0] o_quot,
    output logic [DEN_BITS-1:0] o_rem
);

    logic [DEN_BITS-1:0] r_rem [DIV_BITS];
    logic [DIV_BITS-1:0] r_num [DIV_BITS];
    logic [DIV_BITS-1:0] r_quo [DIV_BITS];
    logic [DEN_BITS-1:0] r_den [DIV_BITS];

    genvar k;
    generate
        for (k = 0; k < DIV_BITS; k++) begin : g_stage
            logic [DEN_BITS-1:0] w_rem_in;
            logic [DIV_BITS-1:0] w_num_in;
            logic [DIV_BITS-1:0] w_quo_in;
            logic [DEN_BITS-1:0] w_den_in;
            logic [DEN_BITS:0]   w_trial;
            logic                w_ge;

            if (k == 0) begin : g_first
                assign w_rem_in = '0;
                assign w_num_in = i_num;
                assign w_quo_in = '0;
                assign w_den_in = i_den;
            end else begin : g_rest
                assign w_rem_in = r_rem[k-1];
                assign w_num_in = r_num[k-1];
                assign w_quo_in = r_quo[k-1];
                assign w_den_in = r_den[k-1];
            end

            // shift in the next dividend bit and try a subtract
            assign w_trial = {w_rem_in, w_num_in[DIV_BITS-1]};
            assign w_ge    = (w_trial >= {1'b0, w_den_in});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? DEN_BITS'(w_trial - {1'b0, w_den_in})
                                     : w_trial[DEN_BITS-1:0];
                    r_num[k] <= {w_num_in[DIV_BITS-2:0], 1'b0};
                    r_quo[k] <= {w_quo_in[DIV_BITS-2:0], w_ge};
                    r_den[k] <= w_den_in;
                end
            end
        end
    endgenerate

    assign o_quot = r_quo[DIV_BITS-1];
    assign o_rem  = r_rem[DIV_BITS-1];

endmodule

// ===== design/im2col_2d_region_generator.sv =====
// im2col region generator top level: range pipeline and descriptor emitter
//
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------
// tap in   | i_valid / o_ready      | tap index, row/col start, offset, taps, pad
// desc out | o_valid / i_ready      | kind, counts, offsets, strides, last
// config   | i_cfg_we               | i_cfg_addr, i_cfg_data
//
// a tap beat can enter every cycle while o_ready is high and passes the input
// register, 14 divider stages, range, multiply and sum stages to the emitter
// each tap leaves 0 to 5 descriptors, one per cycle while i_ready is high;
// the next tap loads into the emitter register as the last of these leaves
// a tap waiting at the sum stage behind a busy emitter freezes the whole pipeline,
// bubbles ahead of it still drain; reset clears valid bits, sets config to one

`include "im2col_2d_region_generator_assert.svh"

module im2col_2d_region_generator import im2c_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [12:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_tap_index,
    input  logic signed [13:0] i_row_start,
    input  logic signed [13:0] i_col_start,
    input  logic [23:0]        i_src_tap_offset,
    input  logic [8:0]         i_tap_count,
    input  logic               i_pad_enable,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_kind,
    output logic [20:0]        o_planes,
    output logic [12:0]        o_rows,
    output logic [24:0]        o_cols,
    output logic [31:0]        o_src_offset,
    output logic signed [32:0] o_dst_offset,
    output logic [24:0]        o_src_stride_plane,
    output logic [18:0]        o_src_stride_row,
    output logic [6:0]         o_src_stride_col,
    output logic [31:0]        o_dst_stride_plane,
    output logic [12:0]        o_dst_stride_row,
    output logic               o_last
);

    // configuration registers
    logic [12:0] r_in_h, r_in_w, r_out_h, r_out_w, r_chan;
    logic [6:0]  r_str_y, r_str_x;
    logic [8:0]  r_batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_h  <= 13'd1;
            r_in_w  <= 13'd1;
            r_out_h <= 13'd1;
            r_out_w <= 13'd1;
            r_str_y <= 7'd1;
            r_str_x <= 7'd1;
            r_chan  <= 13'd1;
            r_batch <= 9'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_IN_H:  r_in_h  <= i_cfg_data;
                CFG_IN_W:  r_in_w  <= i_cfg_data;
                CFG_OUT_H: r_out_h <= i_cfg_data;
                CFG_OUT_W: r_out_w <= i_cfg_data;
                CFG_STR_Y: r_str_y <= i_cfg_data[6:0];
                CFG_STR_X: r_str_x <= i_cfg_data[6:0];
                CFG_CHAN:  r_chan  <= i_cfg_data;
                CFG_BATCH: r_batch <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // effective strides, zero acts as one
    logic [6:0] w_sh, w_sw;
    assign w_sh = (r_str_y == 7'd0) ? 7'd1 : r_str_y;
    assign w_sw = (r_str_x == 7'd0) ? 7'd1 : r_str_x;

    // products of configuration only
    logic [25:0] r_ohow, r_ihiw;
    logic [19:0] r_shiw;
    logic [21:0] r_icnb;

    always_ff @(posedge i_clk) begin
        r_ohow <= 26'(r_out_h) * 26'(r_out_w);
        r_ihiw <= 26'(r_in_h) * 26'(r_in_w);
        r_shiw <= 20'(w_sh) * 20'(r_in_w);
        r_icnb <= 22'(r_chan) * 22'(r_batch);
    end

    // pipeline control
    logic       w_en;
    logic       w_fire;
    logic       w_load_ok;
    logic [4:0] r_mask;
    logic [4:0] w_cur;
    logic       r_vm2;

    assign w_cur     = r_mask & (~r_mask + 5'd1);
    assign w_fire    = o_valid && i_ready;
    assign w_load_ok = (r_mask == 5'd0) || (w_fire && (r_mask == w_cur));
    assign w_en      = !r_vm2 || w_load_ok;
    assign o_ready   = w_en;

    // input stage: divider operands
    logic signed [15:0] w_d2y, w_d2x;
    assign w_d2y = $signed({3'b000, r_in_h}) - 16'sd1 - 16'(i_row_start);
    assign w_d2x = $signed({3'b000, r_in_w}) - 16'sd1 - 16'(i_col_start);

    logic                r_v0;
    t_side               r_s0;
    logic [DIV_BITS-1:0] r_d1y, r_d1x, r_d2y, r_d2x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0.tap  <= i_tap_index;
            r_s0.rs   <= i_row_start;
            r_s0.cs   <= i_col_start;
            r_s0.srct <= i_src_tap_offset;
            r_s0.taps <= i_tap_count;
            r_s0.pad  <= i_pad_enable;
            r_s0.n2y  <= w_d2y[15];
            r_s0.n2x  <= w_d2x[15];
            r_d1y     <= ~i_row_start;
            r_d1x     <= ~i_col_start;
            r_d2y     <= w_d2y[DIV_BITS-1:0];
            r_d2x     <= w_d2x[DIV_BITS-1:0];
        end
    end

    // dividers: last index above the map, last index inside the map
    logic [DIV_BITS-1:0] w_q1y, w_q1x, w_q2y, w_q2x;
    logic [DEN_BITS-1:0] w_r1y, w_r1x, w_r2y, w_r2x;

    im2c_div u_div1y (.i_clk, .i_en(w_en), .i_num(r_d1y), .i_den(w_sh),
                      .o_quot(w_q1y), .o_rem(w_r1y));
    im2c_div u_div1x (.i_clk, .i_en(w_en), .i_num(r_d1x), .i_den(w_sw),
                      .o_quot(w_q1x), .o_rem(w_r1x));
    im2c_div u_div2y (.i_clk, .i_en(w_en), .i_num(r_d2y), .i_den(w_sh),
                      .o_quot(w_q2y), .o_rem(w_r2y));
    im2c_div u_div2x (.i_clk, .i_en(w_en), .i_num(r_d2x), .i_den(w_sw),
                      .o_quot(w_q2x), .o_rem(w_r2x));

    // side fields delayed along with the dividers
    t_side r_dly [DIV_BITS];
    logic  r_vd  [DIV_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_BITS; k++) r_vd[k] <= 1'b0;
        end else if (w_en) begin
            r_vd[0] <= r_v0;
            for (int k = 1; k < DIV_BITS; k++) r_vd[k] <= r_vd[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly[0] <= r_s0;
            for (int k = 1; k < DIV_BITS; k++) r_dly[k] <= r_dly[k-1];
        end
    end

    // range stage: first and last rows and columns
    t_side       w_sd;
    logic        w_rny, w_rnx;
    logic [13:0] w_dy0, w_dx0, w_sy, w_sx, w_ohm1, w_owm1, w_dy1, w_dx1;
    logic        w_empty;
    logic        w_unused_rem;

    assign w_sd   = r_dly[DIV_BITS-1];
    assign w_rny  = w_sd.rs[13];
    assign w_rnx  = w_sd.cs[13];
    assign w_dy0  = w_rny ? (w_q1y + 14'd1) : 14'd0;
    assign w_dx0  = w_rnx ? (w_q1x + 14'd1) : 14'd0;
    assign w_sy   = w_rny ? 14'(w_sh - 7'd1 - w_r1y) : w_sd.rs;
    assign w_sx   = w_rnx ? 14'(w_sw - 7'd1 - w_r1x) : w_sd.cs;
    assign w_ohm1 = {1'b0, r_out_h} - 14'd1;
    assign w_owm1 = {1'b0, r_out_w} - 14'd1;
    assign w_dy1  = (w_q2y < w_ohm1) ? w_q2y : w_ohm1;
    assign w_dx1  = (w_q2x < w_owm1) ? w_q2x : w_owm1;
    assign w_empty = w_sd.n2y || w_sd.n2x
                  || (r_out_h == 13'd0) || (r_out_w == 13'd0)
                  || (w_dy0 > w_dy1) || (w_dx0 > w_dx1)
                  || (w_sy >= {1'b0, r_in_h}) || (w_sx >= {1'b0, r_in_w});
    assign w_unused_rem = ^{w_r2y, w_r2x};

    logic        r_vp, r_p_empty;
    t_side       r_p_side;
    logic [13:0] r_p_dy0, r_p_dx0, r_p_rows, r_p_cols, r_p_sy, r_p_sx;
    logic [13:0] r_p_bel_n, r_p_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (w_en) begin
            r_vp <= r_vd[DIV_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_side  <= w_sd;
            r_p_empty <= w_empty || w_unused_rem && 1'b0;
            r_p_dy0   <= w_dy0;
            r_p_dx0   <= w_dx0;
            r_p_rows  <= w_dy1 - w_dy0 + 14'd1;
            r_p_cols  <= w_dx1 - w_dx0 + 14'd1;
            r_p_sy    <= w_sy;
            r_p_sx    <= w_sx;
            r_p_bel_n <= w_ohm1 - w_dy1;
            r_p_right <= w_owm1 - w_dx1;
        end
    end

    // multiply stage
    logic [34:0] w_dpl;
    assign w_dpl = 35'(r_ohow) * 35'(r_p_side.taps);

    logic        r_vm1, r_m1_empty, r_m1_pad;
    logic [33:0] r_m1_ptap;
    logic [26:0] r_m1_pup, r_m1_pbel, r_m1_prow, r_m1_psrc;
    logic [31:0] r_m1_dpl;
    logic [13:0] r_m1_dx0, r_m1_rows, r_m1_cols, r_m1_sx, r_m1_right;
    logic [23:0] r_m1_srct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm1 <= 1'b0;
        end else if (w_en) begin
            r_vm1 <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_ptap  <= 34'(r_p_side.tap) * 34'(r_ohow);
            r_m1_pup   <= 27'(r_p_dy0) * 27'(r_out_w);
            r_m1_pbel  <= 27'(r_p_bel_n) * 27'(r_out_w);
            r_m1_prow  <= 27'(r_p_rows) * 27'(r_out_w);
            r_m1_psrc  <= 27'(r_p_sy) * 27'(r_in_w);
            r_m1_dpl   <= w_dpl[31:0];
            r_m1_dx0   <= r_p_dx0;
            r_m1_rows  <= r_p_rows;
            r_m1_cols  <= r_p_cols;
            r_m1_sx    <= r_p_sx;
            r_m1_right <= r_p_right;
            r_m1_srct  <= r_p_side.srct;
            r_m1_pad   <= r_p_side.pad;
            r_m1_empty <= r_p_empty;
        end
    end

    // sum stage: main destination and source offsets
    logic        r_m2_empty, r_m2_pad;
    logic [33:0] r_m2_dst;
    logic [31:0] r_m2_src, r_m2_dpl;
    logic [26:0] r_m2_pup, r_m2_pbel, r_m2_prow;
    logic [13:0] r_m2_dx0, r_m2_rows, r_m2_cols, r_m2_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm2 <= 1'b0;
        end else if (w_en) begin
            r_vm2 <= r_vm1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_dst   <= r_m1_ptap + 34'(r_m1_pup) + 34'(r_m1_dx0);
            r_m2_src   <= 32'(r_m1_psrc) + 32'(r_m1_sx) + 32'(r_m1_srct);
            r_m2_dpl   <= r_m1_dpl;
            r_m2_pup   <= r_m1_pup;
            r_m2_pbel  <= r_m1_pbel;
            r_m2_prow  <= r_m1_prow;
            r_m2_dx0   <= r_m1_dx0;
            r_m2_rows  <= r_m1_rows;
            r_m2_cols  <= r_m1_cols;
            r_m2_right <= r_m1_right;
            r_m2_pad   <= r_m1_pad;
            r_m2_empty <= r_m1_empty;
        end
    end

    // pad offsets and pending mask for the emitter
    logic [33:0] w_dst_up, w_dst_bel, w_dst_left, w_dst_right;
    logic [4:0]  w_new_mask;
    logic        w_pads;

    assign w_dst_up    = r_m2_dst - 34'(r_m2_dx0) - 34'(r_m2_pup);
    assign w_dst_bel   = r_m2_dst + 34'(r_m2_prow) - 34'(r_m2_dx0);
    assign w_dst_left  = r_m2_dst - 34'(r_m2_dx0);
    assign w_dst_right = r_m2_dst + 34'(r_m2_cols);
    assign w_pads      = r_m2_pad && !r_m2_empty;

    always_comb begin
        w_new_mask           = 5'd0;
        w_new_mask[MB_UP]    = w_pads && (r_m2_pup != 27'd0);
        w_new_mask[MB_BELOW] = w_pads && (r_m2_pbel != 27'd0);
        w_new_mask[MB_LEFT]  = w_pads && (r_m2_dx0 != 14'd0);
        w_new_mask[MB_RIGHT] = w_pads && (r_m2_right != 14'd0);
        w_new_mask[MB_MAIN]  = !r_m2_empty;
    end

    // emitter registers
    logic [32:0] r_e_dst_main, r_e_dst_up, r_e_dst_bel, r_e_dst_left, r_e_dst_right;
    logic [31:0] r_e_src, r_e_dpl;
    logic [24:0] r_e_up, r_e_bel;
    logic [13:0] r_e_dx0, r_e_rows, r_e_cols, r_e_right;
    logic        w_load;

    assign w_load = r_vm2 && w_load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 5'd0;
        end else if (w_load) begin
            r_mask <= w_new_mask;
        end else if (w_fire) begin
            r_mask <= r_mask & ~w_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_e_dst_main  <= r_m2_dst[32:0];
            r_e_dst_up    <= w_dst_up[32:0];
            r_e_dst_bel   <= w_dst_bel[32:0];
            r_e_dst_left  <= w_dst_left[32:0];
            r_e_dst_right <= w_dst_right[32:0];
            r_e_src       <= r_m2_src;
            r_e_dpl       <= r_m2_dpl;
            r_e_up        <= r_m2_pup[24:0];
            r_e_bel       <= r_m2_pbel[24:0];
            r_e_dx0       <= r_m2_dx0;
            r_e_rows      <= r_m2_rows;
            r_e_cols      <= r_m2_cols;
            r_e_right     <= r_m2_right;
        end
    end

    // output beat selection, lowest pending bit first
    t_kind w_kind;

    assign o_valid            = (r_mask != 5'd0);
    assign o_kind             = w_kind;
    assign o_dst_stride_plane = r_e_dpl;

    always_comb begin
        w_kind             = K_MAIN;
        o_planes           = {8'd0, r_chan};
        o_rows             = r_e_rows[12:0];
        o_cols             = 25'(r_e_cols);
        o_src_offset       = 32'd0;
        o_dst_offset       = r_e_dst_main;
        o_src_stride_plane = 25'd0;
        o_src_stride_row   = 19'd0;
        o_src_stride_col   = 7'd0;
        o_dst_stride_row   = r_out_w;
        o_last             = 1'b0;
        if (w_cur[MB_UP]) begin
            w_kind           = K_UP;
            o_rows           = 13'd1;
            o_cols           = r_e_up;
            o_dst_offset     = r_e_dst_up;
            o_dst_stride_row = 13'd0;
        end else if (w_cur[MB_BELOW]) begin
            w_kind           = K_BELOW;
            o_rows           = 13'd1;
            o_cols           = r_e_bel;
            o_dst_offset     = r_e_dst_bel;
            o_dst_stride_row = 13'd0;
        end else if (w_cur[MB_LEFT]) begin
            w_kind       = K_LEFT;
            o_cols       = 25'(r_e_dx0);
            o_dst_offset = r_e_dst_left;
        end else if (w_cur[MB_RIGHT]) begin
            w_kind       = K_RIGHT;
            o_cols       = 25'(r_e_right);
            o_dst_offset = r_e_dst_right;
        end else begin
            w_kind             = K_MAIN;
            o_planes           = r_icnb[20:0];
            o_src_offset       = r_e_src;
            o_src_stride_plane = r_ihiw[24:0];
            o_src_stride_row   = r_shiw[18:0];
            o_src_stride_col   = w_sw;
            o_last             = 1'b1;
        end
    end

    // checks
    `IM2C_ASSERT_IMP(a_main_closes, o_valid && o_last, $onehot(r_mask))
    `IM2C_ASSERT_IMP(a_main_pending, o_valid, r_mask[MB_MAIN])
    `IM2C_ASSERT_NXT(a_accept_enters, i_valid && o_ready, r_v0)

endmodule

// ===== dv/im2col_2d_region_generator_tb.sv =====
// testbench for the im2col region generator: directed table, random taps, descriptor checks
module im2col_2d_region_generator_tb;
    import im2c_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic [2:0]  kind;
        logic [20:0] planes;
        logic [12:0] rows;
        logic [24:0] cols;
        logic [31:0] src_off;
        logic [32:0] dst_off;
        logic [24:0] ssp;
        logic [18:0] ssr;
        logic [6:0]  ssc;
        logic [31:0] dsp;
        logic [12:0] dsr;
        logic        last;
    } t_desc;

    typedef struct {
        logic [7:0]  tap;
        logic [13:0] rs;
        logic [13:0] cs;
        logic [23:0] off;
        logic [8:0]  taps;
        logic        pad;
        int          typed;   // 0 predicted, 1 one typed descriptor, 2 nothing expected
        t_desc       exp_desc;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [12:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_tap_index = '0;
    logic signed [13:0] i_row_start = '0;
    logic signed [13:0] i_col_start = '0;
    logic [23:0] i_src_tap_offset = '0;
    logic [8:0]  i_tap_count = 9'd1;
    logic        i_pad_enable = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [20:0] o_planes;
    logic [12:0] o_rows;
    logic [24:0] o_cols;
    logic [31:0] o_src_offset;
    logic signed [32:0] o_dst_offset;
    logic [24:0] o_src_stride_plane;
    logic [18:0] o_src_stride_row;
    logic [6:0]  o_src_stride_col;
    logic [31:0] o_dst_stride_plane;
    logic [12:0] o_dst_stride_row;
    logic        o_last;

    im2col_2d_region_generator dut (.*);

    // shadow copy of the geometry registers
    logic [12:0] geo_ih = 1, geo_iw = 1, geo_oh = 1, geo_ow = 1, geo_ch = 1;
    logic [6:0]  geo_sy = 1, geo_sx = 1;
    logic [8:0]  geo_nb = 1;

    t_desc pending_desc[$];
    int    errors = 0;
    int    idle_cycles = 0;
    bit    calm = 1'b0;   // phase with no gaps or stalls
    t_row  dir_rows[$];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // expected descriptors of one tap
    task automatic predict_tap(input logic [7:0] tap, input logic [13:0] rs_b,
                               input logic [13:0] cs_b, input logic [23:0] off,
                               input logic [8:0] taps, input logic pad);
        longint rs, cs, ih, iw, oh, ow, sh, sw, sy, sx, dy0, dy1, ey, dx0, dx1, ex;
        longint up, below, left, right, dst, dplane, rows, cols;
        t_desc d;
        rs = longint'($signed(rs_b));
        cs = longint'($signed(cs_b));
        ih = geo_ih; iw = geo_iw; oh = geo_oh; ow = geo_ow;
        sh = (geo_sy == 0) ? 1 : geo_sy;
        sw = (geo_sx == 0) ? 1 : geo_sx;
        sy = rs; sx = cs; dy0 = 0; dx0 = 0; up = 0; below = 0; left = 0; right = 0;
        if (sy < 0) begin
            dy0 = (-sy + sh - 1) / sh;
            sy += dy0 * sh;
            up = dy0 * ow;
        end
        dy1 = oh - 1;
        ey = dy1 * sh + rs;
        if (ey >= ih) begin
            dy1 -= (ey - ih + sh) / sh;
            below = (oh - dy1 - 1) * ow;
        end
        if (dy0 > dy1 || dy1 < 0 || sy >= ih) return;
        if (sx < 0) begin
            dx0 = (-sx + sw - 1) / sw;
            sx += dx0 * sw;
            left = dx0;
        end
        dx1 = ow - 1;
        ex = dx1 * sw + cs;
        if (ex >= iw) begin
            dx1 -= (ex - iw + sw) / sw;
            right = ow - dx1 - 1;
        end
        if (dx0 > dx1 || dx1 < 0 || sx >= iw) return;
        dst = longint'(tap) * oh * ow + dy0 * ow + dx0;
        dplane = oh * ow * longint'(taps);
        rows = dy1 - dy0 + 1;
        cols = dx1 - dx0 + 1;
        // pad descriptors share zero source fields
        d = '0;
        d.planes = 21'(geo_ch);
        d.dsp = 32'(dplane);
        if (pad) begin
            if (up > 0) begin
                d.kind = K_UP; d.rows = 13'd1; d.cols = 25'(up);
                d.dst_off = 33'(dst - (dx0 + up));
                d.dsr = '0;
                pending_desc.push_back(d);
            end
            if (below > 0) begin
                d.kind = K_BELOW; d.rows = 13'd1; d.cols = 25'(below);
                d.dst_off = 33'(dst + rows * ow - dx0);
                d.dsr = '0;
                pending_desc.push_back(d);
            end
            if (left > 0) begin
                d.kind = K_LEFT; d.rows = 13'(rows); d.cols = 25'(left);
                d.dst_off = 33'(dst - left);
                d.dsr = 13'(ow);
                pending_desc.push_back(d);
            end
            if (right > 0) begin
                d.kind = K_RIGHT; d.rows = 13'(rows); d.cols = 25'(right);
                d.dst_off = 33'(dst + cols);
                d.dsr = 13'(ow);
                pending_desc.push_back(d);
            end
        end
        d.kind = K_MAIN;
        d.planes = 21'(longint'(geo_ch) * longint'(geo_nb));
        d.rows = 13'(rows);
        d.cols = 25'(cols);
        d.src_off = 32'(sy * iw + sx + longint'(off));
        d.dst_off = 33'(dst);
        d.ssp = 25'(ih * iw);
        d.ssr = 19'(sh * iw);
        d.ssc = 7'(sw);
        d.dsr = 13'(ow);
        d.last = 1'b1;
        pending_desc.push_back(d);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t %s expected %0h got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // descriptor sink: random stalls, compare each beat
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_desc e;
        if (o_valid && i_ready && i_rst_n) begin
            if (pending_desc.size() == 0) begin
                $display("%0t unexpected descriptor kind %0d", $time, o_kind);
                errors++;
            end else begin
                e = pending_desc.pop_front();
                check_field("kind", e.kind, o_kind);
                check_field("planes", e.planes, o_planes);
                check_field("rows", e.rows, o_rows);
                check_field("cols", e.cols, o_cols);
                check_field("src_offset", e.src_off, o_src_offset);
                check_field("dst_offset", e.dst_off, $unsigned(o_dst_offset));
                check_field("src_stride_plane", e.ssp, o_src_stride_plane);
                check_field("src_stride_row", e.ssr, o_src_stride_row);
                check_field("src_stride_col", e.ssc, o_src_stride_col);
                check_field("dst_stride_plane", e.dsp, o_dst_stride_plane);
                check_field("dst_stride_row", e.dsr, o_dst_stride_row);
                check_field("last", e.last, o_last);
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            i_ready <= 1'b1;
        end
    end

    // watchdog on beats of either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("im2col_2d_region_generator: mismatch");
            $finish;
        end
    end

    task automatic send_tap(input logic [7:0] tap, input logic [13:0] rs, input logic [13:0] cs,
                            input logic [23:0] off, input logic [8:0] taps, input logic pad);
        int gap;
        i_valid <= 1'b1;
        i_tap_index <= tap;
        i_row_start <= rs;
        i_col_start <= cs;
        i_src_tap_offset <= off;
        i_tap_count <= taps;
        i_pad_enable <= pad;
        do @(posedge i_clk); while (!o_ready);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // let the block drain, including taps that leave nothing
    task automatic wait_idle();
        if (i_valid) begin
            i_valid <= 1'b0;
        end
        while (pending_desc.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_geometry(input logic [12:0] ih, input logic [12:0] iw,
                                  input logic [12:0] oh, input logic [12:0] ow,
                                  input logic [12:0] sy, input logic [12:0] sx,
                                  input logic [12:0] ch, input logic [12:0] nb);
        logic [12:0] vals[8];
        vals = '{ih, iw, oh, ow, sy, sx, ch, nb};
        wait_idle();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= t_cfg_idx'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        geo_ih = ih; geo_iw = iw; geo_oh = oh; geo_ow = ow;
        geo_sy = sy[6:0]; geo_sx = sx[6:0]; geo_ch = ch; geo_nb = nb[8:0];
    endtask

    function automatic t_row mk_row(input logic [7:0] tap, input int rs, input int cs,
                                    input logic [23:0] off, input logic [8:0] taps,
                                    input logic pad);
        t_row r;
        r.tap = tap; r.rs = rs[13:0]; r.cs = cs[13:0]; r.off = off;
        r.taps = taps; r.pad = pad; r.typed = 0; r.exp_desc = '0;
        return r;
    endfunction

    // random tap mostly near the map, sometimes anywhere
    task automatic random_taps(input int count);
        int rs, cs, span;
        logic [7:0]  tap;
        logic [23:0] off;
        logic [8:0]  taps;
        logic        pad;
        for (int n = 0; n < count; n++) begin
            span = (geo_ih > 20) ? 20 : geo_ih + 3;
            rs = $urandom_range(0, 2 * span) - span;
            span = (geo_iw > 20) ? 20 : geo_iw + 3;
            cs = $urandom_range(0, 2 * span) - span;
            if ($urandom_range(0, 9) == 0) rs = $urandom;
            if ($urandom_range(0, 9) == 0) cs = $urandom;
            tap = 8'($urandom);
            off = 24'($urandom);
            taps = 9'($urandom_range(1, 511));
            pad = ($urandom_range(0, 3) != 0);
            // expected beats are queued before the tap can be accepted
            predict_tap(tap, rs[13:0], cs[13:0], off, taps, pad);
            send_tap(tap, rs[13:0], cs[13:0], off, taps, pad);
        end
    endtask

    initial begin
        t_row r;
        // after reset every register is 1: a centered tap is one 1x1 copy
        r = mk_row(8'd5, 0, 0, 24'd100, 9'd9, 1'b1);
        r.typed = 1;
        r.exp_desc = '{kind: K_MAIN, planes: 1, rows: 1, cols: 1, src_off: 100, dst_off: 5,
                       ssp: 1, ssr: 1, ssc: 1, dsp: 9, dsr: 1, last: 1'b1};
        dir_rows.push_back(r);
        r = mk_row(8'd0, -1, 0, 24'd0, 9'd1, 1'b1);   // above the map: empty
        r.typed = 2;
        dir_rows.push_back(r);
        r = mk_row(8'd0, 0, 1, 24'd0, 9'd1, 1'b1);    // right of the map: empty
        r.typed = 2;
        dir_rows.push_back(r);
        // 8x8 map: pads on each border, extremes of every field
        dir_rows.push_back(mk_row(8'd0, -1, -1, 24'd0, 9'd9, 1'b1));
        dir_rows.push_back(mk_row(8'd8, 1, 1, 24'd7, 9'd9, 1'b1));
        dir_rows.push_back(mk_row(8'd4, -2, 2, 24'd3, 9'd9, 1'b1));
        dir_rows.push_back(mk_row(8'd4, 2, -2, 24'd3, 9'd9, 1'b0));
        dir_rows.push_back(mk_row(8'd255, -7, -7, 24'hffffff, 9'd511, 1'b1));
        dir_rows.push_back(mk_row(8'd255, 7, 7, 24'hffffff, 9'd256, 1'b1));
        dir_rows.push_back(mk_row(8'd1, -8192, 0, 24'd0, 9'd1, 1'b1));
        dir_rows.push_back(mk_row(8'd1, 8191, 0, 24'd0, 9'd1, 1'b1));
        dir_rows.push_back(mk_row(8'd1, 0, -8192, 24'd0, 9'd0, 1'b1));
        dir_rows.push_back(mk_row(8'd1, 0, 8191, 24'd0, 9'd0, 1'b1));
        dir_rows.push_back(mk_row(8'd1, -4096, -4096, 24'h555555, 9'd1, 1'b1));
        dir_rows.push_back(mk_row(8'd170, 0, 0, 24'haaaaaa, 9'd170, 1'b1));
        dir_rows.push_back(mk_row(8'd85, 8, 8, 24'd0, 9'd85, 1'b1));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int i = 0; i < dir_rows.size(); i++) begin
            if (i == 3) write_geometry(8, 8, 8, 8, 1, 1, 3, 2);
            r = dir_rows[i];
            if (r.typed == 1) pending_desc.push_back(r.exp_desc);
            else if (r.typed == 0) predict_tap(r.tap, r.rs, r.cs, r.off, r.taps, r.pad);
            send_tap(r.tap, r.rs, r.cs, r.off, r.taps, r.pad);
        end

        // random phases, each with its own geometry
        write_geometry(16, 12, 9, 7, 2, 3, 5, 4);
        random_taps(40);
        calm = 1'b1;
        write_geometry(5, 9, 6, 4, 0, 0, 1, 1);
        random_taps(30);
        calm = 1'b0;
        write_geometry(13'h1fff, 13'h1fff, 13'h1fff, 13'h1fff, 127, 127, 13'h1fff, 511);
        random_taps(25);
        write_geometry(4096, 4096, 4096, 4096, 64, 64, 4096, 256);
        random_taps(25);
        write_geometry(0, 3, 0, 3, 1, 1, 0, 0);
        random_taps(10);
        write_geometry(30, 30, 14, 14, 2, 2, 7, 3);
        random_taps(60);
        write_geometry(11, 6, 11, 6, 1, 2, 2, 2);
        random_taps(50);

        wait_idle();
        if (errors == 0) begin
            $display("im2col_2d_region_generator: match");
        end else begin
            $display("im2col_2d_region_generator: mismatch");
        end
        $finish;
    end
endmodule
